// ----- src/line_of_sight_ray_walk_top_macros.svh -----
// ============================================================================
// Line-of-sight ray walker: assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in the using scope.
// ============================================================================
`ifndef LINE_OF_SIGHT_RAY_WALK_TOP_MACROS_SVH
`define LINE_OF_SIGHT_RAY_WALK_TOP_MACROS_SVH

// Same-cycle implication, checked out of reset
`define LOS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/los_pkg.sv -----
// ============================================================================
// Line-of-sight ray walker: package
// Shared widths, item types and the job record passed from front to back.
// ============================================================================
`default_nettype none

package los_pkg;

    localparam int COORD_W           = 9;
    localparam int CNT_W             = 10;
    localparam int ERR_W             = 12;
    localparam int GRID_SIDE_DEFAULT = 512;
    localparam int RAY_LIMIT_DEFAULT = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_RAY   = 1'b1;

    typedef logic [COORD_W-1:0] coord_t;

    // Input item
    typedef struct packed {
        logic   mode;
        coord_t col_a;
        coord_t row_a;
        coord_t col_b;
        coord_t row_b;
        logic   opaque;
    } in_item_t;

    // Result item
    typedef struct packed {
        coord_t cell_col;
        coord_t cell_row;
        logic   blocked;
        logic   last_cell;
    } out_item_t;

    // Classified job: walk set up in major/minor terms
    typedef struct packed {
        logic   is_ray;
        logic   steep;
        logic   rev;
        logic   ystep_neg;
        coord_t maj_start;
        coord_t min_start;
        coord_t dmaj;
        coord_t dmin;
        coord_t org_col;
        coord_t org_row;
        logic   opaque;
    } job_t;

endpackage

`default_nettype wire

// ----- src/los_front.sv -----
// ============================================================================
// Line-of-sight ray walker: front end
// Takes command transfers, classifies them and sets up the walk geometry.
// ============================================================================
`default_nettype none

module los_front
    import los_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire in_item_t item,
    output logic          push,
    output job_t          job,
    input  wire logic     q_full
);

    logic     hold_valid_reg, hold_valid_next;
    in_item_t hold_reg;
    logic     accept;

    coord_t adc, adr;
    logic   steep, rev;
    coord_t maj1, min1, maj2, min2;
    coord_t s_maj, s_min, e_maj, e_min;

    // Handshake: one item held, released into the queue when it has room
    assign push   = hold_valid_reg && !q_full;
    assign busy   = hold_valid_reg && q_full;
    assign accept = start && !busy;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= item;
        end
    end

    // Geometry: pick the major axis, then walk from the low end of it
    always_comb
    begin
        adc   = (hold_reg.col_b > hold_reg.col_a) ? hold_reg.col_b - hold_reg.col_a
                                                  : hold_reg.col_a - hold_reg.col_b;
        adr   = (hold_reg.row_b > hold_reg.row_a) ? hold_reg.row_b - hold_reg.row_a
                                                  : hold_reg.row_a - hold_reg.row_b;
        steep = adr > adc;
        maj1  = steep ? hold_reg.row_a : hold_reg.col_a;
        min1  = steep ? hold_reg.col_a : hold_reg.row_a;
        maj2  = steep ? hold_reg.row_b : hold_reg.col_b;
        min2  = steep ? hold_reg.col_b : hold_reg.row_b;
        rev   = maj1 > maj2;
        s_maj = rev ? maj2 : maj1;
        s_min = rev ? min2 : min1;
        e_maj = rev ? maj1 : maj2;
        e_min = rev ? min1 : min2;

        job.is_ray    = (hold_reg.mode == MODE_RAY);
        job.steep     = steep;
        job.rev       = rev;
        job.ystep_neg = !(s_min < e_min);
        job.maj_start = s_maj;
        job.min_start = s_min;
        job.dmaj      = e_maj - s_maj;
        job.dmin      = (e_min > s_min) ? e_min - s_min : s_min - e_min;
        job.org_col   = hold_reg.col_a;
        job.org_row   = hold_reg.row_a;
        job.opaque    = hold_reg.opaque;
    end

endmodule

`default_nettype wire

// ----- src/los_queue.sv -----
// ============================================================================
// Line-of-sight ray walker: job queue
// Short FIFO of classified jobs between the front end and the walker.
// ============================================================================
`default_nettype none

module los_queue
    import los_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      head,
    output logic      valid
);

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    job_t            slot_reg [0:QUEUE_DEPTH-1];
    logic [QW-1:0]   wptr_reg, wptr_next;
    logic [QW-1:0]   rptr_reg, rptr_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign full    = (fill_reg == FW'(QUEUE_DEPTH));
    assign valid   = (fill_reg != '0);
    assign head    = slot_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- src/los_back.sv -----
// ============================================================================
// Line-of-sight ray walker: back end
// Owns the opacity grid and the reverse point ring; walks rays, emits cells.
// ============================================================================
`default_nettype none
`include "line_of_sight_ray_walk_top_macros.svh"

module los_back
    import los_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEFAULT,
    parameter int RAY_LIMIT = RAY_LIMIT_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    input  wire job_t job,
    output logic      job_take,
    output out_item_t result,
    output logic      strobe
);

    localparam int GRID_DEPTH = GRID_SIDE * GRID_SIDE;
    localparam int AW         = $clog2(GRID_DEPTH);
    localparam int RING_DEPTH = RAY_LIMIT + 1;
    localparam int RP_W       = $clog2(RING_DEPTH);
    localparam int REM_W      = $clog2(RING_DEPTH + 1);
    localparam logic [COORD_W+1:0] SIDE_L = (COORD_W + 2)'(GRID_SIDE);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FREAD = 8'b0000_0010,
        S_FEMIT = 8'b0000_0100,
        S_RWALK = 8'b0000_1000,
        S_RRING = 8'b0001_0000,
        S_RGRID = 8'b0010_0000,
        S_REMIT = 8'b0100_0000,
        S_ECHO  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // Walk registers
    job_t                      job_reg, job_next;
    coord_t                    maj_reg, maj_next;
    coord_t                    min_reg, min_next;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [RP_W-1:0]           wptr_reg, wptr_next;
    logic [RP_W-1:0]           rptr_reg, rptr_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic                      long_reg, long_next;
    out_item_t                 result_reg, result_next;
    logic                      strobe_reg, strobe_next;

    // Memories
    logic                      grid_mem [0:GRID_DEPTH-1];
    logic [2*COORD_W-1:0]      ring_mem [0:RING_DEPTH-1];
    logic                      grid_rdata_reg;
    logic                      oob_reg;
    logic [2*COORD_W-1:0]      ring_rdata_reg;

    // Step datapath
    coord_t                    pos_col, pos_row;
    coord_t                    ring_col, ring_row;
    coord_t                    rd_col, rd_row;
    logic [AW-1:0]             rd_addr, wr_addr;
    logic                      rd_in_grid, wr_in_grid;
    logic                      grid_we, ring_we;
    logic signed [ERR_W-1:0]   dmin2, dmaj2, err_sub, err_add;
    logic                      minor_step;
    logic [CNT_W-1:0]          cnt_inc;
    logic                      opq, cut, fin;

    assign pos_col  = job_reg.steep ? min_reg : maj_reg;
    assign pos_row  = job_reg.steep ? maj_reg : min_reg;
    assign ring_col = ring_rdata_reg[COORD_W-1:0];
    assign ring_row = ring_rdata_reg[2*COORD_W-1:COORD_W];

    // Grid read address: ring entry while fetching reversed cells
    assign rd_col     = (state_reg == S_RGRID) ? ring_col : pos_col;
    assign rd_row     = (state_reg == S_RGRID) ? ring_row : pos_row;
    assign rd_in_grid = ((COORD_W + 2)'(rd_col) < SIDE_L) && ((COORD_W + 2)'(rd_row) < SIDE_L);
    assign rd_addr    = AW'(rd_row) * AW'(GRID_SIDE) + AW'(rd_col);

    // Grid write port for cell writes
    assign wr_in_grid = ((COORD_W + 2)'(job.org_col) < SIDE_L)
                     && ((COORD_W + 2)'(job.org_row) < SIDE_L);
    assign wr_addr    = AW'(job.org_row) * AW'(GRID_SIDE) + AW'(job.org_col);

    // Bresenham step with doubled error
    assign dmin2      = $signed(ERR_W'({job_reg.dmin, 1'b0}));
    assign dmaj2      = $signed(ERR_W'({job_reg.dmaj, 1'b0}));
    assign err_sub    = err_reg - dmin2;
    assign err_add    = err_sub + dmaj2;
    assign minor_step = err_sub[ERR_W-1];
    assign cnt_inc    = count_reg + 1'b1;

    assign opq = grid_rdata_reg || oob_reg;
    assign cut = (count_reg == CNT_W'(RAY_LIMIT)) && (cnt_inc < CNT_W'(job_reg.dmaj));
    assign fin = (rem_reg == REM_W'(1));

    assign job_take = (state_reg == S_IDLE) && job_valid;
    assign result   = result_reg;
    assign strobe   = strobe_reg;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        maj_next    = maj_reg;
        min_next    = min_reg;
        err_next    = err_reg;
        count_next  = count_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        rem_next    = rem_reg;
        long_next   = long_reg;
        result_next = result_reg;
        strobe_next = 1'b0;
        grid_we     = 1'b0;
        ring_we     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    if (!job.is_ray)
                    begin
                        grid_we = wr_in_grid;
                    end
                    else
                    begin
                        job_next   = job;
                        maj_next   = job.maj_start;
                        min_next   = job.min_start;
                        err_next   = $signed(ERR_W'(job.dmaj));
                        count_next = '0;
                        wptr_next  = '0;
                        state_next = job.rev ? S_RWALK : S_FREAD;
                    end
                end
            end

            S_FREAD:
            begin
                // Grid read of the current cell goes out this cycle
                if (count_reg == CNT_W'(job_reg.dmaj))
                begin
                    state_next = S_ECHO;
                end
                else
                begin
                    state_next = S_FEMIT;
                end
            end

            S_FEMIT:
            begin
                strobe_next           = 1'b1;
                result_next.cell_col  = pos_col;
                result_next.cell_row  = pos_row;
                result_next.blocked   = opq;
                result_next.last_cell = opq || cut;
                if (opq || cut)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    maj_next   = maj_reg + 1'b1;
                    min_next   = minor_step ? (job_reg.ystep_neg ? min_reg - 1'b1
                                                                 : min_reg + 1'b1)
                                            : min_reg;
                    err_next   = minor_step ? err_add : err_sub;
                    count_next = cnt_inc;
                    state_next = S_FREAD;
                end
            end

            S_RWALK:
            begin
                // Record every point; the ring keeps the ones nearest the origin
                ring_we    = 1'b1;
                maj_next   = maj_reg + 1'b1;
                min_next   = minor_step ? (job_reg.ystep_neg ? min_reg - 1'b1
                                                             : min_reg + 1'b1)
                                        : min_reg;
                err_next   = minor_step ? err_add : err_sub;
                count_next = cnt_inc;
                wptr_next  = (wptr_reg == RP_W'(RING_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                if (cnt_inc == CNT_W'(job_reg.dmaj))
                begin
                    rptr_next  = wptr_reg;
                    rem_next   = (cnt_inc < CNT_W'(RING_DEPTH)) ? cnt_inc[REM_W-1:0]
                                                               : REM_W'(RING_DEPTH);
                    long_next  = cnt_inc > CNT_W'(RING_DEPTH);
                    state_next = S_RRING;
                end
            end

            S_RRING:
            begin
                state_next = S_RGRID;
            end

            S_RGRID:
            begin
                state_next = S_REMIT;
            end

            S_REMIT:
            begin
                strobe_next           = 1'b1;
                result_next.cell_col  = ring_col;
                result_next.cell_row  = ring_row;
                result_next.blocked   = opq;
                result_next.last_cell = opq || (fin && long_reg);
                if (opq || (fin && long_reg))
                begin
                    state_next = S_IDLE;
                end
                else if (fin)
                begin
                    state_next = S_ECHO;
                end
                else
                begin
                    rem_next   = rem_reg - 1'b1;
                    rptr_next  = (rptr_reg == '0) ? RP_W'(RING_DEPTH - 1) : rptr_reg - 1'b1;
                    state_next = S_RRING;
                end
            end

            S_ECHO:
            begin
                strobe_next           = 1'b1;
                result_next.cell_col  = job_reg.org_col;
                result_next.cell_row  = job_reg.org_row;
                result_next.blocked   = 1'b0;
                result_next.last_cell = 1'b1;
                state_next            = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // Walk datapath and result register
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        maj_reg    <= maj_next;
        min_reg    <= min_next;
        err_reg    <= err_next;
        count_reg  <= count_next;
        wptr_reg   <= wptr_next;
        rptr_reg   <= rptr_next;
        rem_reg    <= rem_next;
        long_reg   <= long_next;
        result_reg <= result_next;
    end

    // Opacity grid: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[wr_addr] <= job.opaque;
        end
        grid_rdata_reg <= grid_mem[rd_addr];
        oob_reg        <= !rd_in_grid;
    end

    // Reverse point ring, packed as {row, col}
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[wptr_reg] <= {pos_row, pos_col};
        end
        ring_rdata_reg <= ring_mem[rptr_reg];
    end

    // Checks
    `LOS_ASSERT_NEXT(a_femit_strobes, state_reg == S_FEMIT, strobe_reg, "forward emit gave no strobe")
    `LOS_ASSERT_IMPL(a_fwd_limit, state_reg == S_FREAD, count_reg <= CNT_W'(RAY_LIMIT + 1), "forward walk ran past the cell limit")
    `LOS_ASSERT_IMPL(a_last_ends_ray, strobe_reg && result_reg.last_cell, state_reg == S_IDLE, "walker still active after the final cell")
    `LOS_ASSERT_IMPL(a_mid_keeps_ray, strobe_reg && !result_reg.last_cell, state_reg != S_IDLE, "walker idle after a non-final cell")
    `LOS_ASSERT_IMPL(a_rem_nonzero, state_reg == S_REMIT, rem_reg != '0, "reverse emit with no cells left")

endmodule

`default_nettype wire

// ----- src/line_of_sight_ray_walk_top.sv -----
// ============================================================================
// Line-of-sight ray walker: top level
// Grid of opacity bits and a Bresenham ray walker that reports visible cells.
// ============================================================================
// A command is taken on a clock edge with start high and busy low; busy rises
// only when the two-deep job queue and the front end's holding register are
// full. The walker handles a cell write while idle and gives no result for it.
// A ray gives one to RAY_LIMIT+2 results, each shown on result for a single
// cycle with strobe high; there is no backpressure, so the receiver must take
// every strobed result. The walker takes a command from the queue only while
// idle. A ray walked forward along its major axis then takes each walk cell
// through a grid read and an emit, bound by the single registered read port
// of the grid memory, and a last grid read before the closing origin cell
// when it is emitted. A ray whose major axis runs backward first walks the
// whole line from the target, one major step per cycle (up to 511 steps),
// then takes each emitted cell through a ring read, a grid read and an emit,
// and ends with the closing origin cell. A command passes through the front
// end's holding register and the job queue before the walker takes it. The
// grid holds no reset value: cells must be written before a ray reads them.
// ============================================================================
`default_nettype none

module line_of_sight_ray_walk_top
    import los_pkg::*;
#(
    parameter int GRID_SIDE = GRID_SIDE_DEFAULT,
    parameter int RAY_LIMIT = RAY_LIMIT_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire in_item_t item,
    output out_item_t     result,
    output logic          strobe
);

    logic push;
    job_t push_job;
    logic q_full;
    logic q_valid;
    job_t q_head;
    logic q_pop;

    los_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .push   (push),
        .job    (push_job),
        .q_full (q_full)
    );

    los_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .valid    (q_valid)
    );

    los_back #(
        .GRID_SIDE (GRID_SIDE),
        .RAY_LIMIT (RAY_LIMIT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job       (q_head),
        .job_take  (q_pop),
        .result    (result),
        .strobe    (strobe)
    );

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Line-of-sight ray walker: testbench
// Drives cell writes and rays through the start/busy command port, predicts
// every strobed cell from a local copy of the opacity grid, and compares each
// result field by field in order. Cells are always written before a ray can
// read them.
// ============================================================================

module tb_top
    import los_pkg::*;
;

    localparam int SIDE       = GRID_SIDE_DEFAULT;
    localparam int RAY_LIMIT  = RAY_LIMIT_DEFAULT;
    localparam int RING       = RAY_LIMIT + 1;
    localparam int CELL_COUNT = SIDE * SIDE;
    localparam int ITEM_GOAL  = 420;
    localparam int QUIET_TAIL = 60;
    localparam int DRAIN_WAIT = 600;

    // Scoreboard: grid copy, expected cell stream and result checks
    class ray_scoreboard;
        bit        opacity [0:CELL_COUNT-1];
        bit        written [0:CELL_COUNT-1];
        out_item_t pending_cells[$];
        int        mismatches;
        int        checked;
        int        rays;
        int        writes;

        task report(string msg);
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Append one walked cell, answer its opacity
        function bit emit_cell(ref out_item_t cells[$], input int p);
            out_item_t o;
            o.cell_col  = coord_t'(p);
            o.cell_row  = coord_t'(p >> 9);
            o.blocked   = opacity[p];
            o.last_cell = 1'b0;
            cells       = {cells, o};
            return o.blocked;
        endfunction

        // Expected cells of a ray, plus every grid cell the walk may read
        function void trace_ray(input in_item_t it, ref out_item_t cells[$],
                                ref int probes[$]);
            int        ca, ra, cb, rb;
            int        maj1, min1, maj2, min2, swap;
            int        dmaj, dmin, ystep, minor, err, n, k;
            bit        steep, rev;
            int        path[$];
            out_item_t o;
            cells.delete();
            probes.delete();
            ca = int'(it.col_a);
            ra = int'(it.row_a);
            cb = int'(it.col_b);
            rb = int'(it.row_b);
            steep = ((rb > ra) ? rb - ra : ra - rb) > ((cb > ca) ? cb - ca : ca - cb);
            if (steep)
            begin
                maj1 = ra; min1 = ca; maj2 = rb; min2 = cb;
            end
            else
            begin
                maj1 = ca; min1 = ra; maj2 = cb; min2 = rb;
            end
            rev = maj1 > maj2;
            if (rev)
            begin
                swap = maj1; maj1 = maj2; maj2 = swap;
                swap = min1; min1 = min2; min2 = swap;
            end
            dmaj  = maj2 - maj1;
            dmin  = (min2 > min1) ? min2 - min1 : min1 - min2;
            ystep = (min1 < min2) ? 1 : -1;

            // Doubled-error Bresenham walk from the low major end, high end excluded
            err   = dmaj;
            minor = min1;
            for (int m = maj1; m < maj2; m++)
            begin
                path = {path, (steep ? (minor | (m << 9)) : (m | (minor << 9)))};
                err -= 2 * dmin;
                if (err < 0)
                begin
                    minor += ystep;
                    err   += 2 * dmaj;
                end
            end
            n = path.size();

            if (!rev)
            begin
                // Near end of the walk, one cell of margin past the limit
                for (int i = 0; i < n && i <= RAY_LIMIT + 1; i++)
                    probes = {probes, path[i]};
                for (int i = 0; i < n; i++)
                begin
                    if (i > RAY_LIMIT || emit_cell(cells, path[i]))
                    begin
                        cells[cells.size()-1].last_cell = 1'b1;
                        return;
                    end
                end
            end
            else
            begin
                // Walked from the target: emit the tail nearest-first
                for (int i = 0; i < n && i <= RING; i++)
                    probes = {probes, path[n - 1 - i]};
                k = (n < RING) ? n : RING;
                for (int i = 0; i < k; i++)
                begin
                    if (emit_cell(cells, path[n - 1 - i]))
                    begin
                        cells[cells.size()-1].last_cell = 1'b1;
                        return;
                    end
                end
                if (n > RING)
                begin
                    cells[cells.size()-1].last_cell = 1'b1;
                    return;
                end
            end

            // Walk ran out: origin closes the ray, never blocked
            o.cell_col  = coord_t'(ca);
            o.cell_row  = coord_t'(ra);
            o.blocked   = 1'b0;
            o.last_cell = 1'b1;
            cells       = {cells, o};
        endfunction

        function void note_input(in_item_t it);
            out_item_t cells[$];
            int        probes[$];
            int        idx;
            if (it.mode == MODE_WRITE)
            begin
                idx          = int'({it.row_a, it.col_a});
                opacity[idx] = it.opaque;
                written[idx] = 1'b1;
                writes++;
            end
            else
            begin
                trace_ray(it, cells, probes);
                foreach (cells[i])
                    pending_cells = {pending_cells, cells[i]};
                rays++;
            end
        endfunction

        task check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (pending_cells.size() == 0)
            begin
                report($sformatf("unexpected cell col %0d row %0d",
                                 got.cell_col, got.cell_row));
                return;
            end
            want = pending_cells.pop_front();
            if (got.cell_col !== want.cell_col)
                report($sformatf("cell_col %0d, want %0d", got.cell_col, want.cell_col));
            if (got.cell_row !== want.cell_row)
                report($sformatf("cell_row %0d, want %0d", got.cell_row, want.cell_row));
            if (got.blocked !== want.blocked)
                report($sformatf("blocked %b, want %b at col %0d row %0d",
                                 got.blocked, want.blocked, want.cell_col, want.cell_row));
            if (got.last_cell !== want.last_cell)
                report($sformatf("last_cell %b, want %b at col %0d row %0d",
                                 got.last_cell, want.last_cell, want.cell_col,
                                 want.cell_row));
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    out_item_t result;
    logic      strobe;

    ray_scoreboard sb;
    int            items_sent;
    int            hot_col[5] = '{0, 511, 256, 0, 511};
    int            hot_row[5] = '{0, 511, 256, 511, 0};

    line_of_sight_ray_walk_top DUT
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .result (result),
        .strobe (strobe)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result monitor: every strobed cell is a transfer
    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(result);
    end

    function automatic int clip(int v);
        return (v < 0) ? 0 : (v > SIDE - 1) ? SIDE - 1 : v;
    endfunction

    // One command transfer, then maybe an idle burst
    task automatic push_item(in_item_t it);
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_input(it);
        items_sent++;
        if (items_sent < ITEM_GOAL - QUIET_TAIL && (items_sent / 50) % 4 != 3
            && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic put_cell(int c, int r, bit op);
        in_item_t it;
        it.mode   = MODE_WRITE;
        it.col_a  = coord_t'(c);
        it.row_a  = coord_t'(r);
        it.col_b  = coord_t'($urandom);
        it.row_b  = coord_t'($urandom);
        it.opaque = op;
        push_item(it);
    endtask

    // Write any cell the ray may read that is still unknown, then cast it
    task automatic cast_ray(int c0, int r0, int c1, int r1, int opaque_pct);
        in_item_t  ray;
        out_item_t cells[$];
        int        probes[$];
        ray.mode   = MODE_RAY;
        ray.col_a  = coord_t'(c0);
        ray.row_a  = coord_t'(r0);
        ray.col_b  = coord_t'(c1);
        ray.row_b  = coord_t'(r1);
        ray.opaque = ($urandom_range(0, 1) == 1);
        sb.trace_ray(ray, cells, probes);
        foreach (probes[i])
            if (!sb.written[probes[i]])
                put_cell(probes[i] & 'h1FF, probes[i] >> 9,
                         $urandom_range(0, 99) < opaque_pct);
        push_item(ray);
    endtask

    task automatic random_ray();
        int h, c0, r0, c1, r1, sel, len;
        h   = $urandom_range(0, 4);
        c0  = clip(hot_col[h] + $urandom_range(0, 48) - 24);
        r0  = clip(hot_row[h] + $urandom_range(0, 48) - 24);
        sel = $urandom_range(0, 99);
        len = $urandom_range(1, 40);
        if (sel < 50)
        begin
            c1 = clip(c0 + $urandom_range(0, 48) - 24);
            r1 = clip(r0 + $urandom_range(0, 48) - 24);
        end
        else if (sel < 80)
        begin
            c1 = $urandom_range(0, SIDE - 1);
            r1 = $urandom_range(0, SIDE - 1);
        end
        else if (sel < 90)
        begin
            c1 = $urandom_range(0, 1) ? c0 : $urandom_range(0, SIDE - 1);
            r1 = (c1 == c0) ? $urandom_range(0, SIDE - 1) : r0;
        end
        else if (sel < 95)
        begin
            c1 = clip($urandom_range(0, 1) ? c0 + len : c0 - len);
            r1 = clip($urandom_range(0, 1) ? r0 + len : r0 - len);
        end
        else
        begin
            c1 = c0;
            r1 = r0;
        end
        cast_ray(c0, r0, c1, r1, 12);
    endtask

    // Stimulus
    initial
    begin
        int h;
        sb         = new();
        items_sent = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: degenerate, limit, ring depth, blocking and echo cases
        put_cell(0, 0, 1'b0);
        cast_ray(0, 0, 0, 0, 0);
        put_cell(511, 511, 1'b1);
        cast_ray(511, 511, 511, 511, 0);
        cast_ray(0, 0, 511, 0, 0);
        cast_ray(511, 511, 0, 511, 0);
        cast_ray(5, 0, 12, 511, 0);
        cast_ray(300, 511, 290, 0, 0);
        cast_ray(20, 30, 10, 60, 0);
        cast_ray(0, 511, 511, 0, 0);
        cast_ray(100, 100, 117, 105, 0);
        cast_ray(100, 120, 118, 125, 0);
        cast_ray(217, 200, 200, 195, 0);
        cast_ray(218, 210, 200, 214, 0);
        cast_ray(40, 40, 33, 45, 0);
        put_cell(260, 250, 1'b1);
        cast_ray(255, 250, 280, 250, 0);
        put_cell(245, 260, 1'b1);
        cast_ray(250, 260, 230, 260, 0);
        put_cell(300, 300, 1'b1);
        cast_ray(300, 300, 290, 302, 0);
        cast_ray(300, 300, 310, 300, 0);
        put_cell(511, 511, 1'b0);
        cast_ray(511, 511, 480, 505, 0);

        // Random rays with cell writes mixed in as noise
        while (items_sent < ITEM_GOAL)
        begin
            if ($urandom_range(0, 99) < 15)
            begin
                h = $urandom_range(0, 4);
                if ($urandom_range(0, 1))
                    put_cell($urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                             $urandom_range(0, 1) == 1);
                else
                    put_cell(clip(hot_col[h] + $urandom_range(0, 48) - 24),
                             clip(hot_row[h] + $urandom_range(0, 48) - 24),
                             $urandom_range(0, 3) == 0);
            end
            else
                random_ray();
        end
        start <= 1'b0;

        // Drain, then watch for stray cells
        while (sb.pending_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("run covered %0d rays and %0d cell writes, %0d result transfers checked",
                 sb.rays, sb.writes, sb.checked);
        $display("%0d mismatches", sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("timeout with %0d cells still expected", sb.pending_cells.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/los_pkg.sv
src/los_front.sv
src/los_queue.sv
src/los_back.sv
src/line_of_sight_ray_walk_top.sv
bench/tb_top.sv
